[rtl/uefr_pkg.sv]
package uefr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // one-hot frame phases
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_ZERO  = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_CODE  = 6'b001000,
    PH_PARAM = 6'b010000,
    PH_CSUM  = 6'b100000
  } phase_t;

  localparam logic [1:0] KIND_PARAM = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic CFG_ACK_EVENT  = 1'b0;
  localparam logic CFG_CALL_EVENT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic [7:0] frame_event;
    logic       checksum_ok;
    logic       reply_needed;
    logic       last;
    logic       ack_match;
    logic [7:0] call_status;
  } res_t;

endpackage

[rtl/uefr_if.sv]
interface uefr_rx_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data;

  modport source (output valid, output cmd, output data, input ready);
  modport sink (input valid, input cmd, input data, output ready);
endinterface

interface uefr_ev_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic [7:0] frame_event;
  logic       checksum_ok;
  logic       reply_needed;
  logic       last;
  logic       ack_match;
  logic [7:0] call_status;

  modport source (output valid, output kind, output byte_out, output frame_event,
                  output checksum_ok, output reply_needed, output last,
                  output ack_match, output call_status, input ready);
  modport sink (input valid, input kind, input byte_out, input frame_event,
                input checksum_ok, input reply_needed, input last,
                input ack_match, input call_status, output ready);
endinterface

[rtl/uefr_parse.sv]
module uefr_parse
  import uefr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic       cmd,
  input  logic [7:0] data,
  input  logic [7:0] ack_code,
  input  logic [7:0] call_code,
  output logic       has_res,
  output res_t       res
);

  phase_t     phase, phase_next;
  logic [7:0] params_left, params_left_next;
  logic [1:0] param_index, param_index_next;
  logic [7:0] current_event, current_event_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] first_param, first_param_next;
  logic [7:0] second_param, second_param_next;
  logic       second_seen, second_seen_next;
  logic [7:0] acked_opcode, acked_opcode_next;
  logic       acked_valid, acked_valid_next;
  logic [7:0] call_state, call_state_next;

  logic [7:0] sum_add;
  logic [7:0] left_dec;
  logic       match;
  logic       sum_ok;
  logic       is_ack;

  assign sum_add  = running_sum + data;
  assign left_dec = params_left - 8'd1;
  assign match    = acked_valid && (acked_opcode == data);
  assign sum_ok   = (sum_add == 8'd0);
  assign is_ack   = (current_event == ack_code);

  always_comb begin
    phase_next         = phase;
    params_left_next   = params_left;
    param_index_next   = param_index;
    current_event_next = current_event;
    running_sum_next   = running_sum;
    first_param_next   = first_param;
    second_param_next  = second_param;
    second_seen_next   = second_seen;
    acked_opcode_next  = acked_opcode;
    acked_valid_next   = acked_valid;
    call_state_next    = call_state;
    has_res            = 1'b0;
    res                = '0;

    if (cmd == CMD_CHECK) begin
      has_res = 1'b1;
      if (match) begin
        acked_valid_next = 1'b0;
      end
      res.kind      = KIND_ACK;
      res.ack_match = match;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (data == SYNC_BYTE) begin
            phase_next = PH_ZERO;
          end
        end
        PH_ZERO: begin
          phase_next = (data == 8'd0) ? PH_LEN : PH_HUNT;
        end
        PH_LEN: begin
          params_left_next = (data > 8'd1) ? data - 8'd1 : 8'd0;
          running_sum_next = data;
          param_index_next = 2'd0;
          second_seen_next = 1'b0;
          phase_next       = PH_CODE;
        end
        PH_CODE: begin
          current_event_next = data;
          running_sum_next   = sum_add;
          phase_next         = (params_left != 8'd0) ? PH_PARAM : PH_CSUM;
        end
        PH_PARAM: begin
          running_sum_next = sum_add;
          if (param_index == 2'd0) begin
            first_param_next = data;
          end else if (param_index == 2'd1) begin
            second_param_next = data;
            second_seen_next  = 1'b1;
          end
          // saturates: only none, one, or more than one matter
          if (param_index != 2'd2) begin
            param_index_next = param_index + 2'd1;
          end
          params_left_next = left_dec;
          if (left_dec == 8'd0) begin
            phase_next = PH_CSUM;
          end
          has_res      = 1'b1;
          res.kind     = KIND_PARAM;
          res.byte_out = data;
        end
        PH_CSUM: begin
          running_sum_next = sum_add;
          if (sum_ok) begin
            if (is_ack) begin
              if (param_index != 2'd0) begin
                acked_opcode_next = first_param;
                acked_valid_next  = 1'b1;
              end
            end else if (current_event == call_code) begin
              if (second_seen) begin
                call_state_next = second_param;
              end
            end
          end
          phase_next       = PH_HUNT;
          has_res          = 1'b1;
          res.kind         = KIND_END;
          res.checksum_ok  = sum_ok;
          res.reply_needed = sum_ok && !is_ack;
          res.last         = 1'b1;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end

    res.frame_event = current_event;
    res.call_status = call_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      params_left   <= '0;
      param_index   <= '0;
      current_event <= '0;
      running_sum   <= '0;
      first_param   <= '0;
      second_param  <= '0;
      second_seen   <= 1'b0;
      acked_opcode  <= '0;
      acked_valid   <= 1'b0;
      call_state    <= '0;
    end else if (go) begin
      phase         <= phase_next;
      params_left   <= params_left_next;
      param_index   <= param_index_next;
      current_event <= current_event_next;
      running_sum   <= running_sum_next;
      first_param   <= first_param_next;
      second_param  <= second_param_next;
      second_seen   <= second_seen_next;
      acked_opcode  <= acked_opcode_next;
      acked_valid   <= acked_valid_next;
      call_state    <= call_state_next;
    end
  end

  a_param_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PARAM |-> params_left != 8'd0)
    else $error("parameter phase with no bytes left");

  a_match_clears: assert property (@(posedge clk) disable iff (rst)
    go && cmd == CMD_CHECK && match |=> !acked_valid)
    else $error("acknowledge record not cleared on match");

  a_csum_ends_frame: assert property (@(posedge clk) disable iff (rst)
    go && cmd == CMD_BYTE && phase == PH_CSUM |=> phase == PH_HUNT)
    else $error("frame did not end after checksum");

endmodule

[rtl/uefr_out_reg.sv]
module uefr_out_reg
  import uefr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res,
  output logic free,
  uefr_ev_if.source ev
);

  logic valid;
  res_t hold;

  assign free = !valid || ev.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ev.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

  assign ev.valid        = valid;
  assign ev.kind         = hold.kind;
  assign ev.byte_out     = hold.byte_out;
  assign ev.frame_event  = hold.frame_event;
  assign ev.checksum_ok  = hold.checksum_ok;
  assign ev.reply_needed = hold.reply_needed;
  assign ev.last         = hold.last;
  assign ev.ack_match    = hold.ack_match;
  assign ev.call_status  = hold.call_status;

endmodule

[rtl/uart_event_frame_receiver_top.sv]
// path: a word accepted into the input register is parsed while held there, and its
//   result, if any, is loaded into the output register, which drives ev
// throughput: one word per cycle unless ev stalls a word that has a result; the
//   parse between the input register and the output register is combinational
// reset: synchronous rst clears both valid flags, returns the parser to sync hunt,
//   clears all parser state and loads the event code registers to 0 and 2
module uart_event_frame_receiver_top
  import uefr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  uefr_rx_if.sink    rx,
  uefr_ev_if.source  ev,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration registers
  logic [7:0] ack_code;
  logic [7:0] call_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code  <= 8'd0;
      call_code <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACK_EVENT:  ack_code  <= cfg_data;
        CFG_CALL_EVENT: call_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register holding one received word
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_data;

  logic       has_res;
  res_t       res;
  logic       out_free;
  logic       advance;

  // a word with no result never waits on the output side
  assign advance  = in_valid && (out_free || !has_res);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_cmd  <= rx.cmd;
      in_data <= rx.data;
    end
  end

  // frame parser: state updates when the held word moves on
  uefr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .cmd       (in_cmd),
    .data      (in_data),
    .ack_code  (ack_code),
    .call_code (call_code),
    .has_res   (has_res),
    .res       (res)
  );

  // result register toward the consumer
  uefr_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (advance && has_res),
    .res  (res),
    .free (out_free),
    .ev   (ev)
  );

endmodule

[dv/uart_event_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps

module uart_event_frame_receiver_top_tb;
  import uefr_pkg::*;

  // cycles with no word moving on either side before the run is called hung
  localparam int STUCK_LIMIT = 4000;
  // the longest receiver hold-off, long enough to fill the block and stall rx
  localparam int HOLD_CYCLES = 300;
  // words per random phase
  localparam int PHASE_WORDS = 150;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } word_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       typed;
    res_t       want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  uefr_rx_if rx();
  uefr_ev_if ev();

  uart_event_frame_receiver_top DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .ev        (ev),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // frame parser model: own copy of the event code registers and parse state
  // ---------------------------------------------------------------------------
  logic [7:0] ack_code;
  logic [7:0] call_code;
  phase_t     m_phase;
  logic [7:0] m_left;
  logic [7:0] m_index;
  logic [7:0] m_event;
  logic [7:0] m_sum;
  logic [7:0] m_first;
  logic [7:0] m_second;
  logic       m_second_seen;
  logic [7:0] m_acked_opcode;
  logic       m_acked_valid;
  logic [7:0] m_call_state;

  res_t  pending_events [$];
  word_t frame_words [$];
  row_t  dir_rows [0:25];

  int  fail_count;
  int  words_used;
  int  stuck_cycles;
  bit  calm;
  bit  stall_long;

  function automatic void clear_parser();
    ack_code       = 8'h00;
    call_code      = 8'h02;
    m_phase        = PH_HUNT;
    m_left         = '0;
    m_index        = '0;
    m_event        = '0;
    m_sum          = '0;
    m_first        = '0;
    m_second       = '0;
    m_second_seen  = 1'b0;
    m_acked_opcode = '0;
    m_acked_valid  = 1'b0;
    m_call_state   = '0;
  endfunction

  // parse one accepted word, return 1 when it produces an event word
  function automatic bit parse_word(logic c, logic [7:0] d, output res_t r);
    bit has;
    bit good;
    has = 1'b0;
    r   = '0;
    if (c == CMD_CHECK) begin
      // answered at once, frame parse left alone
      r.kind      = KIND_ACK;
      r.ack_match = m_acked_valid && (m_acked_opcode == d);
      if (r.ack_match) m_acked_valid = 1'b0;
      has = 1'b1;
    end else begin
      case (m_phase)
        PH_HUNT: begin
          if (d == SYNC_BYTE) m_phase = PH_ZERO;
        end
        PH_ZERO: begin
          // a nonzero byte here is dropped, never taken as a fresh sync
          m_phase = (d == 8'h00) ? PH_LEN : PH_HUNT;
        end
        PH_LEN: begin
          m_left        = (d > 8'd1) ? d - 8'd1 : 8'd0;
          m_sum         = d;
          m_index       = '0;
          m_second_seen = 1'b0;
          m_phase       = PH_CODE;
        end
        PH_CODE: begin
          m_event = d;
          m_sum   = m_sum + d;
          m_phase = (m_left != 8'd0) ? PH_PARAM : PH_CSUM;
        end
        PH_PARAM: begin
          m_sum = m_sum + d;
          if (m_index == 8'd0) begin
            m_first = d;
          end else if (m_index == 8'd1) begin
            m_second      = d;
            m_second_seen = 1'b1;
          end
          if (m_index != 8'hFF) m_index = m_index + 8'd1;
          m_left = m_left - 8'd1;
          if (m_left == 8'd0) m_phase = PH_CSUM;
          r.kind     = KIND_PARAM;
          r.byte_out = d;
          has        = 1'b1;
        end
        PH_CSUM: begin
          m_sum = m_sum + d;
          good  = (m_sum == 8'd0);
          if (good) begin
            // ack code wins when both codes are the same
            if (m_event == ack_code) begin
              if (m_index != 8'd0) begin
                m_acked_opcode = m_first;
                m_acked_valid  = 1'b1;
              end
            end else if (m_event == call_code) begin
              if (m_second_seen) m_call_state = m_second;
            end
          end
          r.kind         = KIND_END;
          r.checksum_ok  = good;
          r.reply_needed = good && (m_event != ack_code);
          r.last         = 1'b1;
          m_phase        = PH_HUNT;
          has            = 1'b1;
        end
        default: m_phase = PH_HUNT;
      endcase
    end
    if (has) begin
      r.frame_event = m_event;
      r.call_status = m_call_state;
    end
    return has;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting and event checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  task automatic compare_event(res_t got, res_t want);
    if (got.kind !== want.kind) report_mismatch("kind", 8'(got.kind), 8'(want.kind));
    if (got.byte_out !== want.byte_out)
      report_mismatch("byte_out", got.byte_out, want.byte_out);
    if (got.frame_event !== want.frame_event)
      report_mismatch("frame_event", got.frame_event, want.frame_event);
    if (got.checksum_ok !== want.checksum_ok)
      report_mismatch("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
    if (got.reply_needed !== want.reply_needed)
      report_mismatch("reply_needed", 8'(got.reply_needed), 8'(want.reply_needed));
    if (got.last !== want.last) report_mismatch("last", 8'(got.last), 8'(want.last));
    if (got.ack_match !== want.ack_match)
      report_mismatch("ack_match", 8'(got.ack_match), 8'(want.ack_match));
    if (got.call_status !== want.call_status)
      report_mismatch("call_status", got.call_status, want.call_status);
  endtask

  // every event word taken at an edge is matched against the oldest expectation
  always @(posedge clk) begin : check_events
    res_t got;
    res_t want;
    if (!rst && ev.valid && ev.ready) begin
      got.kind         = ev.kind;
      got.byte_out     = ev.byte_out;
      got.frame_event  = ev.frame_event;
      got.checksum_ok  = ev.checksum_ok;
      got.reply_needed = ev.reply_needed;
      got.last         = ev.last;
      got.ack_match    = ev.ack_match;
      got.call_status  = ev.call_status;
      if (pending_events.size() == 0) begin
        report_mismatch("event word with nothing expected", 8'(got.kind), 8'h00);
      end else begin
        want = pending_events.pop_front();
        compare_event(got, want);
      end
    end
  end

  // hang watchdog: reset on any word moving on either channel
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (ev.valid && ev.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event receiver: random ready bursts, steady ready when calm, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    ev.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (calm) begin
        ev.ready <= 1'b1;
        @(posedge clk);
      end else if (stall_long) begin
        // hold off long enough for the block to back up into rx
        ev.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_long = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        ev.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        ev.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // rx sender
  // ---------------------------------------------------------------------------

  // offer one word, wait for it to be taken, then predict its event word
  task automatic send_word(logic c, logic [7:0] d, logic typed = 1'b0, res_t want = '0);
    res_t r;
    bit   has;
    if (!calm && $urandom_range(0, 7) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.cmd   <= c;
    rx.data  <= d;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    // bytes dropped while hunting do not count toward the phase size
    if (c == CMD_CHECK || m_phase != PH_HUNT || d == SYNC_BYTE) words_used++;
    has = parse_word(c, d, r);
    if (typed) pending_events.push_back(want);
    else if (has) pending_events.push_back(r);
  endtask

  // stop offering, wait for every expected event, then let the pipe drain
  task automatic settle();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both event code registers, written only while the block is idle
  task automatic set_codes(logic [7:0] ack_v, logic [7:0] call_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACK_EVENT;
    cfg_data  <= ack_v;
    @(posedge clk);
    cfg_index <= CFG_CALL_EVENT;
    cfg_data  <= call_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ack_code  = ack_v;
    call_code = call_v;
  endtask

  function automatic row_t row(logic c, logic [7:0] d);
    row_t t;
    t       = '0;
    t.cmd   = c;
    t.data  = d;
    return t;
  endfunction

  function automatic row_t typed_row(logic c, logic [7:0] d, res_t w);
    row_t t;
    t       = row(c, d);
    t.typed = 1'b1;
    t.want  = w;
    return t;
  endfunction

  function automatic void push_byte(logic [7:0] d);
    frame_words.push_back('{cmd: CMD_BYTE, data: d});
  endfunction

  // one random burst: mostly well-formed frames, the rest checks and noise
  task automatic make_burst();
    int         r;
    int         n;
    int         len;
    logic [7:0] code;
    logic [7:0] sum;
    logic [7:0] p;
    frame_words.delete();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = $urandom_range(0, 99);
      if (n < 85) len = $urandom_range(0, 6);
      else if (n < 97) len = $urandom_range(7, 20);
      else len = $urandom_range(200, 255);
      case ($urandom_range(0, 2))
        0:       code = ack_code;
        1:       code = call_code;
        default: code = 8'($urandom);
      endcase
      push_byte(SYNC_BYTE);
      push_byte(8'h00);
      push_byte(8'(len));
      push_byte(code);
      sum = 8'(len) + code;
      for (int i = 1; i < len; i++) begin
        p = 8'($urandom);
        push_byte(p);
        sum = sum + p;
        // an occasional check in the middle of a frame
        if ($urandom_range(0, 19) == 0)
          frame_words.push_back('{cmd: CMD_CHECK, data: 8'($urandom)});
      end
      // mostly a good checksum, now and then a random one
      if ($urandom_range(0, 9) == 0) push_byte(8'($urandom));
      else push_byte(8'h00 - sum);
    end else if (r < 82) begin
      // check against the recorded opcode half the time
      if ($urandom_range(0, 1) == 0)
        frame_words.push_back('{cmd: CMD_CHECK, data: m_acked_opcode});
      else
        frame_words.push_back('{cmd: CMD_CHECK, data: 8'($urandom)});
    end else if (r < 92) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
    end else begin
      // broken start: sync followed by a random second byte
      push_byte(SYNC_BYTE);
      push_byte(8'($urandom));
    end
  endtask

  task automatic run_phase(int target, bit pause_mid);
    int start;
    bit paused;
    start  = words_used;
    paused = 1'b0;
    while (words_used - start < target) begin
      make_burst();
      foreach (frame_words[k]) send_word(frame_words[k].cmd, frame_words[k].data);
      // sender pause until every expected event word has come back
      if (pause_mid && !paused && words_used - start >= target / 2) begin
        settle();
        paused = 1'b1;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rx.valid   = 1'b0;
    rx.cmd     = CMD_BYTE;
    rx.data    = 8'h00;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ACK_EVENT;
    cfg_data   = 8'h00;
    fail_count = 0;
    words_used = 0;
    calm       = 1'b0;
    stall_long = 1'b0;
    clear_parser();

    // directed frames under the reset codes (ack 0, call status 2)
    dir_rows = '{
      // check with nothing recorded answers no match
      typed_row(CMD_CHECK, 8'h00, '{kind: KIND_ACK, default: '0}),
      // dropped while hunting
      row(CMD_BYTE, 8'h55),
      // sync then a nonzero byte, which is not a new sync
      row(CMD_BYTE, SYNC_BYTE), row(CMD_BYTE, 8'h01), row(CMD_BYTE, 8'h00),
      // call status frame, length 3, check in the middle, second param 0xff
      row(CMD_BYTE, SYNC_BYTE), row(CMD_BYTE, 8'h00), row(CMD_BYTE, 8'h03),
      row(CMD_BYTE, 8'h02), row(CMD_BYTE, 8'h11), row(CMD_CHECK, 8'h7F),
      row(CMD_BYTE, 8'hFF), row(CMD_BYTE, 8'hEB),
      // ack frame of length one: no params, nothing recorded
      row(CMD_BYTE, SYNC_BYTE), row(CMD_BYTE, 8'h00), row(CMD_BYTE, 8'h01),
      row(CMD_BYTE, 8'h00), row(CMD_BYTE, 8'hFF),
      // ack frame recording opcode 0x5a
      row(CMD_BYTE, SYNC_BYTE), row(CMD_BYTE, 8'h00), row(CMD_BYTE, 8'h02),
      row(CMD_BYTE, 8'h00), row(CMD_BYTE, 8'h5A), row(CMD_BYTE, 8'hA4),
      // first check matches and clears, the second one misses
      row(CMD_CHECK, 8'h5A),
      typed_row(CMD_CHECK, 8'h5A,
                '{kind: KIND_ACK, frame_event: 8'h00, call_status: 8'hFF, default: '0})
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_codes(8'h00, 8'h02);

    foreach (dir_rows[k])
      send_word(dir_rows[k].cmd, dir_rows[k].data, dir_rows[k].typed, dir_rows[k].want);
    settle();

    // random phases, each under its own pair of event codes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_codes(8'hFF, 8'h00);
        1:       set_codes(8'h00, 8'hFF);
        2:       set_codes(8'($urandom), 8'($urandom));
        3:       set_codes(8'h55, 8'h55);
        4:       set_codes(8'($urandom), 8'($urandom));
        default: set_codes(8'h00, 8'h02);
      endcase
      if (ph == 1) stall_long = 1'b1;
      // last phase runs with no idling on either side
      if (ph == 5) calm = 1'b1;
      run_phase(PHASE_WORDS, ph == 2);
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
